// File: rtl/miller_rabin_prime_test_128_unit_macros.svh
// Assertion helpers for the prime test unit.
`ifndef MILLER_RABIN_PRIME_TEST_128_UNIT_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_128_UNIT_MACROS_SVH

`ifndef SYNTH
`define MRPT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mrpt assertion failed");
`define MRPT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mrpt assertion failed");
`else
`define MRPT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MRPT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/mrpt_pkg.sv
`default_nettype none

package mrpt_pkg;

    localparam int HI_W      = 63;
    localparam int LO_W      = 64;
    localparam int RES_W     = HI_W + LO_W;
    localparam int R_W       = $clog2(RES_W);
    localparam int NUM_BASES = 9;
    localparam int MAX_BASES = 12;
    localparam int BIDX_W    = $clog2(MAX_BASES + 1);
    localparam int BASE_W    = 6;

    typedef logic [BASE_W-1:0] base_t;

    localparam base_t BASE_TABLE [MAX_BASES] = '{
        base_t'(2), base_t'(3), base_t'(5), base_t'(7), base_t'(11), base_t'(13),
        base_t'(17), base_t'(19), base_t'(23), base_t'(29), base_t'(31), base_t'(37)
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SPLIT,
        S_BASE,
        S_POW,
        S_POW_SQ,
        S_MUL,
        S_CHKX,
        S_SQ_LOOP,
        S_SQ_CHK,
        S_FINISH
    } state_t;

    // where a finished modular product goes
    typedef enum logic [1:0] {
        MD_ACC,
        MD_G,
        MD_X
    } mdest_t;

endpackage

`default_nettype wire

// File: rtl/mrpt_req_if.sv
`default_nettype none

interface mrpt_req_if
    import mrpt_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [HI_W-1:0] n_high;
    logic [LO_W-1:0] n_low;

    modport source (output valid, output n_high, output n_low, input ready);
    modport sink   (input valid, input n_high, input n_low, output ready);
endinterface

`default_nettype wire

// File: rtl/mrpt_rsp_if.sv
`default_nettype none

interface mrpt_rsp_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

// File: rtl/miller_rabin_prime_test_128_unit.sv
// Miller-Rabin prime test on a 127-bit candidate {n_high, n_low} with the
// fixed bases 2..23, one candidate at a time. All modular arithmetic runs
// through a single 127-bit modular adder. A modular multiply steps through
// the multiplier bit by bit, doubling the multiplicand and adding it into
// the product for each set bit, and then closes. One base costs a squaring
// and the two sequencing states S_POW and S_POW_SQ per exponent bit, a
// multiply per set bit of the exponent, and up to r-1 further squarings.
// Candidates below four, and even candidates, go from the check straight to
// the finish. A composite usually fails at the first base, but only after one
// full exponentiation. The input is not ready while a candidate is under
// test. A new candidate is taken while the previous verdict waits in the
// output register.
`default_nettype none
`include "miller_rabin_prime_test_128_unit_macros.svh"

module miller_rabin_prime_test_128_unit
    import mrpt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mrpt_req_if.sink   req,
    mrpt_rsp_if.source rsp
);

    state_t              state_reg, state_next;
    mdest_t              dest_reg, dest_next;
    logic [RES_W-1:0]    n_reg, n_next;
    logic [RES_W-1:0]    d_reg, d_next;
    logic [RES_W-1:0]    g_reg, g_next;
    logic [RES_W-1:0]    e_reg, e_next;
    logic [RES_W-1:0]    acc_reg, acc_next;
    logic [RES_W-1:0]    ma_reg, ma_next;
    logic [RES_W-1:0]    mb_reg, mb_next;
    logic [RES_W-1:0]    mp_reg, mp_next;
    logic [R_W-1:0]      r_reg, r_next;
    logic [R_W-1:0]      sq_i_reg, sq_i_next;
    logic [BIDX_W-1:0]   bidx_reg, bidx_next;
    logic                res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_prime_reg, out_prime_next;

    logic [RES_W-1:0]    nm1;
    logic [RES_W-1:0]    one_res;
    logic [RES_W-1:0]    base_val;
    logic                base_done;
    logic                mb_zero;
    logic                e_zero;
    logic                x_is_nm1;
    logic                x_pass;
    logic                sq_over;
    logic                out_free;
    logic                chk_small_no;
    logic                chk_small_yes;
    logic                chk_even;

    // shared modular adder
    logic [RES_W-1:0]    op_a;
    logic [RES_W-1:0]    op_b;
    logic [RES_W:0]      add_sum;
    logic [RES_W:0]      add_red;
    logic [RES_W-1:0]    add_res;

    assign op_a    = (mb_reg[0]) ? mp_reg : ma_reg;
    assign op_b    = ma_reg;
    assign add_sum = {1'b0, op_a} + {1'b0, op_b};
    assign add_red = add_sum - {1'b0, n_reg};
    assign add_res = (add_sum >= {1'b0, n_reg}) ? add_red[RES_W-1:0] : add_sum[RES_W-1:0];

    // n is odd whenever nm1 is used
    assign nm1      = {n_reg[RES_W-1:1], 1'b0};
    assign one_res  = {{(RES_W-1){1'b0}}, 1'b1};
    assign base_val = (bidx_reg < BIDX_W'(NUM_BASES))
                    ? {{(RES_W-BASE_W){1'b0}}, BASE_TABLE[bidx_reg]}
                    : '0;
    assign base_done     = (bidx_reg >= BIDX_W'(NUM_BASES)) || (base_val >= n_reg);
    assign mb_zero       = (mb_reg == '0);
    assign e_zero        = (e_reg == '0);
    assign x_is_nm1      = (acc_reg == nm1);
    assign x_pass        = (acc_reg == one_res) || x_is_nm1;
    assign sq_over       = (sq_i_reg >= r_reg);
    assign out_free      = !out_valid_reg || rsp.ready;
    assign chk_small_no  = (n_reg[RES_W-1:1] == '0);
    assign chk_small_yes = (n_reg[RES_W-1:2] == '0) && n_reg[1];
    assign chk_even      = !n_reg[0];

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.is_prime = out_prime_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (chk_small_no || chk_small_yes || chk_even)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (d_reg[0])
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                state_next = base_done ? S_FINISH : S_POW;
            end
            S_POW:
            begin
                priority if (e_zero)
                begin
                    state_next = S_CHKX;
                end
                else if (e_reg[0])
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_POW_SQ;
                end
            end
            S_POW_SQ:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mb_zero)
                begin
                    unique case (dest_reg)
                        MD_ACC:  state_next = S_POW_SQ;
                        MD_G:    state_next = S_POW;
                        MD_X:    state_next = S_SQ_CHK;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CHKX:
            begin
                state_next = x_pass ? S_BASE : S_SQ_LOOP;
            end
            S_SQ_LOOP:
            begin
                state_next = sq_over ? S_FINISH : S_MUL;
            end
            S_SQ_CHK:
            begin
                state_next = x_is_nm1 ? S_BASE : S_SQ_LOOP;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and output register next values
    always_comb
    begin
        dest_next      = dest_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        g_next         = g_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        mp_next        = mp_reg;
        r_next         = r_reg;
        sq_i_next      = sq_i_reg;
        bidx_next      = bidx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_prime_next = out_prime_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    n_next = {req.n_high, req.n_low};
                end
            end
            S_CHECK:
            begin
                d_next    = nm1;
                r_next    = '0;
                bidx_next = '0;
                res_next  = chk_small_yes && !chk_small_no;
            end
            S_SPLIT:
            begin
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    r_next = r_reg + R_W'(1);
                end
            end
            S_BASE:
            begin
                res_next = 1'b1;
                g_next   = base_val;
                e_next   = d_reg;
                acc_next = one_res;
            end
            S_POW:
            begin
                ma_next   = g_reg;
                mb_next   = acc_reg;
                mp_next   = '0;
                dest_next = MD_ACC;
            end
            S_POW_SQ:
            begin
                ma_next   = g_reg;
                mb_next   = g_reg;
                mp_next   = '0;
                dest_next = MD_G;
            end
            S_MUL:
            begin
                priority if (mb_zero)
                begin
                    unique case (dest_reg)
                        MD_ACC:
                        begin
                            acc_next = mp_reg;
                        end
                        MD_G:
                        begin
                            g_next = mp_reg;
                            e_next = e_reg >> 1;
                        end
                        MD_X:
                        begin
                            acc_next = mp_reg;
                        end
                        default:
                        begin
                            acc_next = acc_reg;
                        end
                    endcase
                end
                else if (mb_reg[0])
                begin
                    // add the multiplicand, clear the low bit, double next cycle
                    mp_next = add_res;
                    mb_next = {mb_reg[RES_W-1:1], 1'b0};
                end
                else
                begin
                    ma_next = add_res;
                    mb_next = mb_reg >> 1;
                end
            end
            S_CHKX:
            begin
                sq_i_next = R_W'(1);
                if (x_pass)
                begin
                    bidx_next = bidx_reg + BIDX_W'(1);
                end
            end
            S_SQ_LOOP:
            begin
                res_next  = 1'b0;
                ma_next   = acc_reg;
                mb_next   = acc_reg;
                mp_next   = '0;
                dest_next = MD_X;
                if (!sq_over)
                begin
                    sq_i_next = sq_i_reg + R_W'(1);
                end
            end
            S_SQ_CHK:
            begin
                if (x_is_nm1)
                begin
                    bidx_next = bidx_reg + BIDX_W'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = res_reg;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg      <= dest_next;
        n_reg         <= n_next;
        d_reg         <= d_next;
        g_reg         <= g_next;
        e_reg         <= e_next;
        acc_reg       <= acc_next;
        ma_reg        <= ma_next;
        mb_reg        <= mb_next;
        mp_reg        <= mp_next;
        r_reg         <= r_next;
        sq_i_reg      <= sq_i_next;
        bidx_reg      <= bidx_next;
        res_reg       <= res_next;
        out_prime_reg <= out_prime_next;
    end

    // residues fed to the adder stay reduced
    `MRPT_ASSERT_IMP(a_mul_reduced, clk, rst_n, (state_reg == S_MUL), ((mp_reg < n_reg) && (ma_reg < n_reg)))
    // squaring count never passes r
    `MRPT_ASSERT_IMP(a_sq_bound, clk, rst_n, (state_reg == S_SQ_LOOP), (sq_i_reg <= r_reg))
    // a verdict waiting at the output is never overwritten by a finish
    `MRPT_ASSERT_NXT(a_finish_hold, clk, rst_n, ((state_reg == S_FINISH) && !out_free), ((state_reg == S_FINISH) && out_valid_reg))

endmodule

`default_nettype wire

// File: verif/tb_miller_rabin_prime_test_128_unit.sv
`timescale 1ns / 1ps

module tb_miller_rabin_prime_test_128_unit;
    import mrpt_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int RSP_HOLD_CYCLES = 3000;
    localparam int WITNESS_COUNT   = 9;
    localparam int unsigned WITNESSES [WITNESS_COUNT] = '{2, 3, 5, 7, 11, 13, 17, 19, 23};

    typedef logic [RES_W-1:0] cand_t;

    typedef struct {
        cand_t n;
        logic  prime;
    } verdict_t;

    logic clk;
    logic rst_n;

    mrpt_req_if req_ch ();
    mrpt_rsp_if rsp_ch ();

    miller_rabin_prime_test_128_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    verdict_t verdicts_due [$];
    int       mismatches;
    int       items_sent;
    int       verdicts_checked;
    int       primes_seen;
    int       idle_cycles;
    logic     steady;
    logic     rsp_held;
    event     rsp_hold_ev;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic cand_t mul_mod(input cand_t a, input cand_t b, input cand_t m);
        logic [2*RES_W-1:0] prod;
        prod = {{RES_W{1'b0}}, a} * {{RES_W{1'b0}}, b};
        return cand_t'(prod % {{RES_W{1'b0}}, m});
    endfunction

    function automatic cand_t pow_mod(input cand_t g, input cand_t e, input cand_t m);
        cand_t acc;
        acc = cand_t'(1);
        while (e != '0)
        begin
            if (e[0])
                acc = mul_mod(acc, g, m);
            g = mul_mod(g, g, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic predict_primality(input cand_t n);
        cand_t d;
        cand_t nm1;
        cand_t x;
        int    r;
        int    b;
        int    i;
        logic  passed;
        logic  verdict;
        if (n < 2)
            return 1'b0;
        if (n == 2 || n == 3)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        nm1 = n - 1;
        d = nm1;
        r = 0;
        while (!d[0])
        begin
            d = d >> 1;
            r++;
        end
        verdict = 1'b1;
        for (b = 0; b < WITNESS_COUNT && verdict; b++)
        begin
            // a witness at or above n ends the test with a prime answer
            if (cand_t'(WITNESSES[b]) >= n)
                break;
            x = pow_mod(cand_t'(WITNESSES[b]), d, n);
            passed = (x == cand_t'(1)) || (x == nm1);
            for (i = 1; i < r && !passed; i++)
            begin
                x = mul_mod(x, x, n);
                passed = (x == nm1);
            end
            if (!passed)
                verdict = 1'b0;
        end
        return verdict;
    endfunction

    // ---------------------------------------------------------------
    // Checking and response side
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input cand_t n, input logic got,
                                   input logic want);
        $display("[%0t] MISMATCH %s: n=0x%032h is_prime got %0b want %0b",
                 $time, what, n, got, want);
        mismatches++;
    endtask

    initial
    begin
        verdict_t v;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch("unexpected result", '0, rsp_ch.is_prime, 1'bx);
                else
                begin
                    v = verdicts_due.pop_front();
                    verdicts_checked++;
                    if (rsp_ch.is_prime !== v.prime)
                        report_mismatch("wrong verdict", v.n, rsp_ch.is_prime, v.prime);
                    if (v.prime)
                        primes_seen++;
                end
            end
            rsp_ch.ready <= !rsp_held && (steady || $urandom_range(99) >= 9);
        end
    end

    // long hold-off on the result side, counted here
    initial
    begin
        rsp_held <= 1'b0;
        forever
        begin
            @(rsp_hold_ev);
            rsp_held <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clk);
            rsp_held <= 1'b0;
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles, %0d verdicts pending",
                         $time, idle_cycles, verdicts_due.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic send_candidate(input cand_t n);
        verdict_t v;
        v.n = n;
        v.prime = predict_primality(n);
        if (!steady && $urandom_range(99) < 9)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.n_high <= n[RES_W-1:LO_W];
        req_ch.n_low  <= n[LO_W-1:0];
        do
            @(posedge clk);
        while (!req_ch.ready);
        verdicts_due.push_back(v);
        items_sent++;
    endtask

    function automatic int pick_width();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(20, 2);
        else if (roll < 90)
            return $urandom_range(64, 21);
        return $urandom_range(RES_W, 65);
    endfunction

    // random candidate of exactly the given bit length, mostly odd
    function automatic cand_t random_candidate(input int bits);
        logic [127:0] raw;
        cand_t        n;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        n = raw[RES_W-1:0] & ((cand_t'(1) << bits) - 1);
        n[bits-1] = 1'b1;
        if ($urandom_range(99) < 80)
            n[0] = 1'b1;
        return n;
    endfunction

    task automatic test_small_candidates();
        send_candidate(cand_t'(0));
        send_candidate(cand_t'(1));
        send_candidate(cand_t'(2));
        send_candidate(cand_t'(3));
        send_candidate(cand_t'(4));
        send_candidate(cand_t'(5));
        send_candidate(cand_t'(7));
        send_candidate(cand_t'(9));
        send_candidate(cand_t'(23));
        send_candidate(cand_t'(25));
        send_candidate(cand_t'(29));
        send_candidate(cand_t'(65537));
    endtask

    task automatic test_pseudoprimes();
        // a Carmichael number, then strong pseudoprimes to ever longer runs of the leading witnesses
        send_candidate(cand_t'(561));
        send_candidate(cand_t'(2047));
        send_candidate(cand_t'(1373653));
        send_candidate(cand_t'(64'd3215031751));
        send_candidate(cand_t'(64'd3825123056546413051));
    endtask

    task automatic test_field_extremes();
        send_candidate({{HI_W{1'b1}}, {LO_W{1'b0}}});
        send_candidate({{HI_W{1'b0}}, {LO_W{1'b1}}});
        send_candidate({63'd1, 64'd1});
        send_candidate(cand_t'(64'h1FFF_FFFF_FFFF_FFFF));
        send_candidate(cand_t'(64'hFFFF_FFFF_FFFF_FFC5));
        send_candidate({{HI_W{1'b1}}, {LO_W{1'b1}}});
    endtask

    task automatic test_random_candidates(input int count);
        for (int k = 0; k < count; k++)
            send_candidate(random_candidate(pick_width()));
    endtask

    task automatic test_steady_stream(input int count);
        steady = 1'b1;
        for (int k = 0; k < count; k++)
            send_candidate(random_candidate(pick_width()));
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        // stall the result side while quick candidates keep coming
        steady = 1'b1;
        -> rsp_hold_ev;
        for (int k = 0; k < 8; k++)
            send_candidate(random_candidate($urandom_range(12, 2)));
        steady = 1'b0;
    endtask

    initial
    begin
        mismatches       = 0;
        items_sent       = 0;
        verdicts_checked = 0;
        primes_seen      = 0;
        steady           = 1'b0;
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.n_high <= '0;
        req_ch.n_low  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_candidates();
        test_pseudoprimes();
        test_field_extremes();
        test_random_candidates(45);
        test_backpressure();
        test_steady_stream(25);
        req_ch.valid <= 1'b0;

        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (verdicts_due.size() != 0)
            report_mismatch("missing result", verdicts_due[0].n, 1'bx, verdicts_due[0].prime);
        $display("Sent %0d candidates, checked %0d verdicts, %0d of them prime",
                 items_sent, verdicts_checked, primes_seen);
        $display("Covered small cases, pseudoprimes, field extremes, widths 2..127 and stalls");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/mrpt_pkg.sv
rtl/mrpt_req_if.sv
rtl/mrpt_rsp_if.sv
rtl/miller_rabin_prime_test_128_unit.sv
verif/tb_miller_rabin_prime_test_128_unit.sv
